@@ src/calendar_date_check_weekday_core_assert.svh @@
// assertion macros for the date check core
`ifndef CALENDAR_DATE_CHECK_WEEKDAY_CORE_ASSERT_SVH
`define CALENDAR_DATE_CHECK_WEEKDAY_CORE_ASSERT_SVH

// same-cycle implication
`define CDCW_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication
`define CDCW_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

@@ src/cdcw_pkg.sv @@
package cdcw_pkg;

	localparam logic [3:0] DATE_TEXT_LEN = 4'd8;
	localparam logic [2:0] WD_INVALID    = 3'd7;

	typedef struct packed {
		logic [3:0] text_length;
		logic [7:0] char_0;
		logic [7:0] char_1;
		logic [7:0] char_2;
		logic [7:0] char_3;
		logic [7:0] char_4;
		logic [7:0] char_5;
		logic [7:0] char_6;
		logic [7:0] char_7;
	} date_word_t;

	typedef struct packed {
		logic       date_valid;
		logic       leap_year;
		logic [2:0] weekday;
	} verdict_word_t;

	// days in month, february follows the leap flag
	function automatic logic [4:0] month_len(input logic [6:0] mo, input logic leap);
		logic [4:0] n;
		unique case (mo)
			7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: n = 5'd31;
			7'd4, 7'd6, 7'd9, 7'd11:                    n = 5'd30;
			7'd2:                                       n = leap ? 5'd29 : 5'd28;
			default:                                    n = 5'd0;
		endcase
		return n;
	endfunction

	// floor(2.6*m - 0.2) with march as m = 1
	function automatic logic [4:0] month_offset(input logic [6:0] mo);
		logic [4:0] n;
		unique case (mo)
			7'd1:    n = 5'd28;
			7'd2:    n = 5'd31;
			7'd3:    n = 5'd2;
			7'd4:    n = 5'd5;
			7'd5:    n = 5'd7;
			7'd6:    n = 5'd10;
			7'd7:    n = 5'd12;
			7'd8:    n = 5'd15;
			7'd9:    n = 5'd18;
			7'd10:   n = 5'd20;
			7'd11:   n = 5'd23;
			7'd12:   n = 5'd25;
			default: n = 5'd0;
		endcase
		return n;
	endfunction

endpackage

@@ src/cdcw_date_if.sv @@
interface cdcw_date_if
	import cdcw_pkg::*;
();
	logic       valid;
	logic       ready;
	date_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ src/cdcw_verdict_if.sv @@
interface cdcw_verdict_if
	import cdcw_pkg::*;
();
	logic          valid;
	logic          ready;
	verdict_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ src/calendar_date_check_weekday_core.sv @@
// Date check and day of week core.
// The date channel takes one word per handshake: an eight-character
// YYYYMMDD text and its length. The verdict channel returns one word per
// date: a valid flag, a leap-year flag and the weekday (0 Sunday to 6
// Saturday, 7 for an invalid date).
// Both channels use valid/ready; a word moves at a clock edge with both high.
// The date is registered, checked in one combinational pass, and the verdict
// registered; a date waits in the input register while the receiver stalls.
// Throughput is one date per cycle while verdicts are taken, set by the
// single check pass between the input and output registers.
// When the receiver stalls, the verdict register holds and the input
// register still takes a date if it is empty; after that date.ready drops
// until the verdict is taken.
// Reset (arst_n low) empties both registers; no verdict is presented and
// date.ready is high once reset is released.
module calendar_date_check_weekday_core
	import cdcw_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	cdcw_date_if.sink      date,
	cdcw_verdict_if.source verdict
);

	date_word_t    date_s1;
	logic          v_s1;
	verdict_word_t res_s2;
	logic          v_s2;
	verdict_word_t res_c;
	logic          adv1;
	logic          take;

	assign adv1       = !v_s2 || verdict.ready;
	assign date.ready = !v_s1 || adv1;
	assign take       = date.valid && date.ready;

	cdcw_eval u_eval (
		.word    (date_s1),
		.verdict (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (take) begin
				v_s1 <= 1'b1;
			end else if (adv1) begin
				v_s1 <= 1'b0;
			end
			if (adv1) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			date_s1 <= date.data;
		end
		if (adv1 && v_s1) begin
			res_s2 <= res_c;
		end
	end

	assign verdict.valid = v_s2;
	assign verdict.data  = res_s2;

	`include "calendar_date_check_weekday_core_assert.svh"

	`CDCW_ASSERT_IMP(a_wd_marks_valid, v_s2, res_s2.date_valid == (res_s2.weekday != WD_INVALID))
	`CDCW_ASSERT_NXT(a_take_loads_s1, take, v_s1 && (date_s1 == $past(date.data)))
	`CDCW_ASSERT_NXT(a_s1_holds, v_s1 && !adv1, v_s1 && $stable(date_s1))
	`CDCW_ASSERT_NXT(a_s1_moves_on, v_s1 && adv1, v_s2 && (res_s2 == $past(res_c)))

endmodule

@@ src/cdcw_eval.sv @@
module cdcw_eval
	import cdcw_pkg::*;
(
	input  date_word_t    word,
	output verdict_word_t verdict
);

	logic       dg0, dg1, dg2, dg3, dg4, dg5, dg6, dg7;
	logic       year_dg, all_dg;
	logic [3:0] d0, d1, d2, d3, d4, d5, d6, d7;
	logic [6:0] cen, yy, mo, dy;
	logic       yr_ge, leap, valid, early;
	logic [6:0] ay_y, ay_c;
	logic [4:0] lim, moff;
	logic [8:0] sum;
	logic [4:0] fold1;
	logic [3:0] fold2;
	logic [2:0] wd;

	function automatic logic is_dig(input logic [7:0] ch);
		return (ch >= 8'h30) && (ch <= 8'h39);
	endfunction

	function automatic logic [6:0] two_dig(input logic [3:0] hi, input logic [3:0] lo);
		return 7'(hi) * 7'd10 + 7'(lo);
	endfunction

	always_comb begin
		dg0 = is_dig(word.char_0);
		dg1 = is_dig(word.char_1);
		dg2 = is_dig(word.char_2);
		dg3 = is_dig(word.char_3);
		dg4 = is_dig(word.char_4);
		dg5 = is_dig(word.char_5);
		dg6 = is_dig(word.char_6);
		dg7 = is_dig(word.char_7);
		year_dg = dg0 && dg1 && dg2 && dg3;
		all_dg  = year_dg && dg4 && dg5 && dg6 && dg7;

		d0 = word.char_0[3:0];
		d1 = word.char_1[3:0];
		d2 = word.char_2[3:0];
		d3 = word.char_3[3:0];
		d4 = word.char_4[3:0];
		d5 = word.char_5[3:0];
		d6 = word.char_6[3:0];
		d7 = word.char_7[3:0];

		cen = two_dig(d0, d1);
		yy  = two_dig(d2, d3);
		mo  = two_dig(d4, d5);
		dy  = two_dig(d6, d7);

		// year >= 1583, leap by 4/100/400/4000 on century and year-in-century
		yr_ge = (cen > 7'd15) || ((cen == 7'd15) && (yy >= 7'd83));
		leap  = year_dg && yr_ge &&
			(((yy[1:0] == 2'd0) && (yy != 7'd0)) ||
			 ((yy == 7'd0) && (cen[1:0] == 2'd0) &&
			  !((d1 == 4'd0) && (d0[1:0] == 2'd0))));

		lim   = month_len(mo, leap);
		valid = (word.text_length == DATE_TEXT_LEN) && all_dg &&
			(mo >= 7'd1) && (mo <= 7'd12) && (dy >= 7'd1) && (dy <= 7'(lim));

		// jan and feb count in the preceding year, 0000 wraps to 9999
		early = (mo <= 7'd2);
		if (early && (yy == 7'd0)) begin
			ay_y = 7'd99;
			ay_c = (cen == 7'd0) ? 7'd99 : cen - 7'd1;
		end else if (early) begin
			ay_y = yy - 7'd1;
			ay_c = cen;
		end else begin
			ay_y = yy;
			ay_c = cen;
		end

		moff = month_offset(mo);
		sum  = 9'(dy) + 9'(moff) + 9'(ay_y[1:0]) * 9'd5 + 9'(ay_y) * 9'd3 +
			9'(ay_c[1:0]) * 9'd5;

		// mod 7 by folding octal digits, since 8 = 1 mod 7
		fold1 = 5'(sum[8:6]) + 5'(sum[5:3]) + 5'(sum[2:0]);
		fold2 = 4'(fold1[4:3]) + 4'(fold1[2:0]);
		wd    = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];

		verdict.date_valid = valid;
		verdict.leap_year  = leap;
		verdict.weekday    = valid ? wd : WD_INVALID;
	end

endmodule

@@ tb/tb_calendar_date_check_weekday_core.sv @@
module tb_calendar_date_check_weekday_core
	import cdcw_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned RANDOM_DATES = 1400;
	localparam int unsigned QUIET_FIRST = 500;
	localparam int unsigned QUIET_LAST = 800;
	localparam int unsigned HOLD_AT = 620;
	localparam int unsigned HOLD_CYCLES = 300;

	class weekday_scoreboard;
		verdict_word_t pending[$];
		int unsigned accepted_count;
		int unsigned mismatch_count;

		function bit ascii_digit(logic [7:0] c);
			return c >= 8'h30 && c <= 8'h39;
		endfunction

		function int unsigned digit_of(logic [7:0] c);
			return int'(c - 8'h30) & 15;
		endfunction

		function verdict_word_t predict_verdict(date_word_t w);
			bit yr_ok, rest_ok, leap, ok;
			int unsigned yr, mo, dy, lim, mm, py, cent, yy;
			verdict_word_t v;
			yr = 0;
			mo = 0;
			dy = 0;
			yr_ok = ascii_digit(w.char_0) && ascii_digit(w.char_1) &&
				ascii_digit(w.char_2) && ascii_digit(w.char_3);
			rest_ok = ascii_digit(w.char_4) && ascii_digit(w.char_5) &&
				ascii_digit(w.char_6) && ascii_digit(w.char_7);
			if (yr_ok) begin
				yr = digit_of(w.char_0) * 1000 + digit_of(w.char_1) * 100 +
					digit_of(w.char_2) * 10 + digit_of(w.char_3);
			end
			if (rest_ok) begin
				mo = digit_of(w.char_4) * 10 + digit_of(w.char_5);
				dy = digit_of(w.char_6) * 10 + digit_of(w.char_7);
			end
			leap = yr_ok && yr >= 1583 &&
				((yr % 4 == 0 && yr % 100 != 0) || (yr % 400 == 0 && yr % 4000 != 0));
			ok = 1'b0;
			if (w.text_length == DATE_TEXT_LEN && yr_ok && rest_ok &&
					mo >= 1 && mo <= 12 && dy >= 1) begin
				case (mo)
					2: lim = leap ? 29 : 28;
					4, 6, 9, 11: lim = 30;
					default: lim = 31;
				endcase
				ok = dy <= lim;
			end
			v.date_valid = ok;
			v.leap_year = leap;
			v.weekday = WD_INVALID;
			if (ok) begin
				// january and february count as months 11 and 12 of the year before
				if (mo <= 2) begin
					mm = mo + 10;
					py = (yr == 0) ? 9999 : yr - 1;
				end else begin
					mm = mo - 2;
					py = yr;
				end
				cent = py / 100;
				yy = py % 100;
				v.weekday = 3'((dy + (26 * mm - 2) / 10 + 5 * (yy % 4) + 3 * yy +
					5 * (cent % 4)) % 7);
			end
			return v;
		endfunction

		function void note_date(date_word_t w);
			pending.push_back(predict_verdict(w));
			accepted_count++;
		endfunction

		function void check_verdict(verdict_word_t got);
			verdict_word_t want;
			if (pending.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected verdict word %b/%b/%0d",
						got.date_valid, got.leap_year, got.weekday);
				return;
			end
			want = pending.pop_front();
			if (got.date_valid !== want.date_valid || got.leap_year !== want.leap_year ||
					got.weekday !== want.weekday) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("verdict mismatch: expected %b/%b/%0d, got %b/%b/%0d",
						want.date_valid, want.leap_year, want.weekday,
						got.date_valid, got.leap_year, got.weekday);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int unsigned cycle_count = 0;
	bit gaps_on;
	weekday_scoreboard sb;

	cdcw_date_if date_ch();
	cdcw_verdict_if verdict_ch();

	calendar_date_check_weekday_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.date(date_ch),
		.verdict(verdict_ch)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_calendar_date_check_weekday_core: errors");
			$finish;
		end
	end

	function automatic date_word_t make_date(int unsigned len, int unsigned yr,
			int unsigned mo, int unsigned dy);
		date_word_t w;
		w.text_length = 4'(len);
		w.char_0 = 8'h30 + 8'(yr / 1000 % 10);
		w.char_1 = 8'h30 + 8'(yr / 100 % 10);
		w.char_2 = 8'h30 + 8'(yr / 10 % 10);
		w.char_3 = 8'h30 + 8'(yr % 10);
		w.char_4 = 8'h30 + 8'(mo / 10 % 10);
		w.char_5 = 8'h30 + 8'(mo % 10);
		w.char_6 = 8'h30 + 8'(dy / 10 % 10);
		w.char_7 = 8'h30 + 8'(dy % 10);
		return w;
	endfunction

	// overwrite one character, char_0 is idx 0
	function automatic date_word_t with_char(date_word_t w, int unsigned idx,
			logic [7:0] c);
		date_word_t r;
		r = w;
		r[63 - 8 * idx -: 8] = c;
		return r;
	endfunction

	function automatic date_word_t random_date();
		int unsigned r, yr, mo, dy, len;
		date_word_t w;
		r = $urandom_range(99);
		case ($urandom_range(3))
			0: yr = $urandom_range(99) * 100;
			1: yr = 1580 + $urandom_range(7);
			default: yr = $urandom_range(9999);
		endcase
		mo = $urandom_range(1, 12);
		dy = ($urandom_range(3) == 0) ? $urandom_range(28, 31) : $urandom_range(1, 31);
		len = 8;
		if (r >= 80 && r < 92) begin
			case ($urandom_range(3))
				0: len = $urandom_range(15);
				1: mo = ($urandom_range(1) == 0) ? 0 : $urandom_range(13, 99);
				2: dy = ($urandom_range(1) == 0) ? 0 : $urandom_range(32, 99);
				default: len = 8;
			endcase
		end
		w = make_date(len, yr, mo, dy);
		if (r >= 80 && r < 92 && $urandom_range(1) == 0)
			w = with_char(w, $urandom_range(7), 8'($urandom));
		if (r >= 92) begin
			w.text_length = 4'($urandom);
			w[63:32] = $urandom;
			w[31:0] = $urandom;
		end
		return w;
	endfunction

	task automatic send_date(date_word_t w);
		while (gaps_on && $urandom_range(99) < 25) begin
			date_ch.valid <= 1'b0;
			@(posedge clk);
		end
		date_ch.valid <= 1'b1;
		date_ch.data <= w;
		@(posedge clk);
		while (!date_ch.ready)
			@(posedge clk);
		sb.note_date(w);
	endtask

	task automatic send_directed();
		date_word_t leap_day;
		leap_day = make_date(8, 2024, 2, 29);
		send_date(leap_day);
		send_date(make_date(8, 2023, 2, 29));
		send_date(make_date(8, 0, 1, 1));
		send_date(make_date(8, 0, 2, 28));
		send_date(make_date(8, 0, 2, 29));
		send_date(make_date(8, 9999, 12, 31));
		send_date(make_date(8, 1582, 12, 31));
		send_date(make_date(8, 1583, 1, 1));
		send_date(make_date(8, 1600, 2, 29));
		send_date(make_date(8, 1700, 2, 29));
		send_date(make_date(8, 2000, 2, 29));
		send_date(make_date(8, 4000, 2, 29));
		send_date(make_date(8, 8000, 3, 1));
		send_date(make_date(8, 2023, 4, 31));
		send_date(make_date(8, 2023, 0, 10));
		send_date(make_date(8, 2023, 13, 1));
		send_date(make_date(8, 2023, 12, 0));
		send_date(make_date(8, 2023, 1, 32));
		send_date(make_date(0, 2024, 2, 29));
		send_date(make_date(7, 2024, 2, 29));
		send_date(make_date(9, 2024, 2, 29));
		send_date(make_date(15, 2024, 2, 29));
		send_date(with_char(leap_day, 2, 8'h2F));
		send_date(with_char(leap_day, 7, 8'h3A));
		send_date(with_char(leap_day, 0, 8'hFF));
		send_date(with_char(leap_day, 5, 8'h00));
	endtask

	// verdict side, with one long hold-off once the input is busy
	initial begin
		int unsigned hold_left;
		bit held;
		hold_left = 0;
		held = 1'b0;
		verdict_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (verdict_ch.valid && verdict_ch.ready)
				sb.check_verdict(verdict_ch.data);
			if (!held && sb.accepted_count >= HOLD_AT) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				verdict_ch.ready <= 1'b0;
			end else begin
				verdict_ch.ready <= !gaps_on || ($urandom_range(99) >= 25);
			end
		end
	end

	initial begin
		sb = new();
		gaps_on = 1'b1;
		arst_n <= 1'b0;
		date_ch.valid <= 1'b0;
		date_ch.data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_directed();
		for (int unsigned i = 0; i < RANDOM_DATES; i++) begin
			gaps_on = !(i >= QUIET_FIRST && i < QUIET_LAST);
			send_date(random_date());
		end
		gaps_on = 1'b1;
		date_ch.valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.mismatch_count == 0 && sb.pending.size() == 0)
			$display("tb_calendar_date_check_weekday_core: clean");
		else
			$display("tb_calendar_date_check_weekday_core: errors");
		$finish;
	end

endmodule
